### src/tspd_pkg.sv
// Shared constants and types for the transport stream PES payload demultiplexer.
package tspd_pkg;

   localparam logic [8:0] PACKET_BYTES = 9'd188;
   localparam logic [7:0] LAST_POS     = 8'(PACKET_BYTES - 9'd1);

   localparam logic [7:0] SYNC_BYTE    = 8'h47;
   localparam logic [7:0] FIXED_BODY   = 8'd4;
   localparam logic [7:0] NO_BODY      = 8'd255;
   localparam logic [3:0] HDR_LEN_SKIP = 4'd8;

   localparam int unsigned MAP_ROWS  = 256;
   localparam int unsigned ROW_BITS  = 32;
   localparam int unsigned ROW_AW    = $clog2(MAP_ROWS);
   localparam int unsigned BIT_AW    = $clog2(ROW_BITS);

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_BAD_SYNC = 2'd1;
   localparam logic [1:0] KIND_NO_START = 2'd2;
   localparam logic [1:0] KIND_OVERRUN  = 2'd3;

   typedef enum logic [2:0] {
      PH_SYNC,
      PH_PIDH,
      PH_PIDL,
      PH_CTRL,
      PH_ALEN,
      PH_BODY,
      PH_CODE,
      PH_PESH
   } phase_type;

endpackage

### src/ts_pes_payload_demux_unit.sv
// Top level of the transport stream PES payload demultiplexer.
// The rsp_ outputs are registered, so a result appears in the cycle after its byte transfer.
// Throughput: one byte per cycle while req_stall is low; the active PID map is a 256 x 32 memory read at the PID byte.
// Reset: synchronous; afterwards a clearing pass over all 256 map rows holds req_stall high.
// After any error the block keeps taking bytes but gives no results until reset.
module ts_pes_payload_demux_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [12:0] rsp_stream_pid,
   output logic        rsp_packet_last
);

   // Active PID map storage.
   logic [tspd_pkg::ROW_BITS-1:0] map_mem [tspd_pkg::MAP_ROWS];
   logic [tspd_pkg::ROW_BITS-1:0] mem_rd_ff;
   logic                          mem_we;
   logic [tspd_pkg::ROW_AW-1:0]   mem_waddr;
   logic [tspd_pkg::ROW_BITS-1:0] mem_wdata;
   logic                          mem_re;
   logic [tspd_pkg::ROW_AW-1:0]   mem_raddr;

   // Clearing pass.
   logic                        clr_ff, clr_in;
   logic [tspd_pkg::ROW_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // Parser state.
   tspd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [12:0] pid_ff, pid_in;
   logic        start_ff, start_in;
   logic [3:0]  skip_ff, skip_in;
   logic [7:0]  begin_ff, begin_in;
   logic        halted_ff, halted_in;
   logic [tspd_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic        load_ff, load_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [12:0] opid_ff, opid_in;
   logic        olast_ff, olast_in;

   // Decisions for the current byte.
   logic        accept;
   logic        last;
   logic        active;
   logic [8:0]  begin_sum;
   logic        emit_data;
   logic        err;
   logic [1:0]  err_kind;
   logic        set_map;
   logic        cont;
   logic [7:0]  b;

   assign b         = req_stream_byte;
   assign req_stall = clr_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign last      = pos_ff >= tspd_pkg::LAST_POS;
   assign active    = row_ff[pid_ff[tspd_pkg::BIT_AW-1:0]];
   assign begin_sum = {1'b0, pos_ff} + 9'd1 + {1'b0, b};

   // Next-state logic of the parser.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      pid_in    = pid_ff;
      start_in  = start_ff;
      skip_in   = skip_ff;
      begin_in  = begin_ff;
      halted_in = halted_ff;
      emit_data = 1'b0;
      err       = 1'b0;
      err_kind  = tspd_pkg::KIND_DATA;
      set_map   = 1'b0;
      cont      = 1'b0;
      if (accept && !halted_ff) begin
         case (phase_ff)
            tspd_pkg::PH_SYNC: begin
               if (b != tspd_pkg::SYNC_BYTE) begin
                  err      = 1'b1;
                  err_kind = tspd_pkg::KIND_BAD_SYNC;
               end else begin
                  phase_in = tspd_pkg::PH_PIDH;
               end
            end
            tspd_pkg::PH_PIDH: begin
               start_in = b[6];
               pid_in   = {b[4:0], 8'd0};
               phase_in = tspd_pkg::PH_PIDL;
            end
            tspd_pkg::PH_PIDL: begin
               pid_in   = {pid_ff[12:8], b};
               phase_in = tspd_pkg::PH_CTRL;
            end
            tspd_pkg::PH_CTRL: begin
               if (b[5]) begin
                  phase_in = tspd_pkg::PH_ALEN;
               end else begin
                  begin_in = tspd_pkg::FIXED_BODY;
                  phase_in = tspd_pkg::PH_BODY;
               end
            end
            tspd_pkg::PH_ALEN: begin
               if (begin_sum >= tspd_pkg::PACKET_BYTES) begin
                  if (start_ff && active) begin
                     err      = 1'b1;
                     err_kind = tspd_pkg::KIND_NO_START;
                  end
                  begin_in = tspd_pkg::NO_BODY;
               end else begin
                  begin_in = begin_sum[7:0];
               end
               phase_in = tspd_pkg::PH_BODY;
            end
            default: begin
            end
         endcase

         if (!err) begin
            if (phase_in == tspd_pkg::PH_BODY && pos_ff >= begin_in) begin
               if (start_in) begin
                  phase_in = tspd_pkg::PH_CODE;
                  skip_in  = 4'd0;
                  cont     = 1'b1;
               end else if (active) begin
                  emit_data = 1'b1;
               end
            end else if (phase_in == tspd_pkg::PH_CODE || phase_in == tspd_pkg::PH_PESH) begin
               cont = 1'b1;
            end

            if (cont && phase_in == tspd_pkg::PH_CODE) begin
               if (b != ((skip_in >= 4'd2) ? 8'd1 : 8'd0)) begin
                  if (active) begin
                     err      = 1'b1;
                     err_kind = tspd_pkg::KIND_NO_START;
                  end else begin
                     start_in = 1'b0;
                     begin_in = tspd_pkg::NO_BODY;
                     phase_in = tspd_pkg::PH_BODY;
                  end
               end else if (skip_in >= 4'd2) begin
                  set_map  = 1'b1;
                  skip_in  = 4'd3;
                  phase_in = tspd_pkg::PH_PESH;
               end else begin
                  skip_in = skip_in + 4'd1;
                  if (last && active) begin
                     err      = 1'b1;
                     err_kind = tspd_pkg::KIND_NO_START;
                  end
               end
            end else if (cont && phase_in == tspd_pkg::PH_PESH) begin
               if (skip_in < tspd_pkg::HDR_LEN_SKIP) begin
                  skip_in = skip_in + 4'd1;
                  if (last) begin
                     err      = 1'b1;
                     err_kind = tspd_pkg::KIND_OVERRUN;
                  end
               end else if (begin_sum >= tspd_pkg::PACKET_BYTES) begin
                  err      = 1'b1;
                  err_kind = tspd_pkg::KIND_OVERRUN;
               end else begin
                  begin_in = begin_sum[7:0];
                  start_in = 1'b0;
                  phase_in = tspd_pkg::PH_BODY;
               end
            end
         end

         if (err) begin
            halted_in = 1'b1;
         end else if (last) begin
            pos_in   = 8'd0;
            phase_in = tspd_pkg::PH_SYNC;
         end else begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   // Output, map access and clearing logic.
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      mem_we     = 1'b0;
      mem_waddr  = pid_ff[12:tspd_pkg::BIT_AW];
      mem_wdata  = row_ff | (tspd_pkg::ROW_BITS'(1) << pid_ff[tspd_pkg::BIT_AW-1:0]);
      mem_re     = accept && !halted_ff && phase_ff == tspd_pkg::PH_PIDL;
      mem_raddr  = {pid_ff[12:8], b[7:tspd_pkg::BIT_AW]};
      load_in    = mem_re;
      row_in     = row_ff;
      if (clr_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_cnt_ff;
         mem_wdata  = '0;
         clr_cnt_in = clr_cnt_ff + tspd_pkg::ROW_AW'(1);
         if (clr_cnt_ff == tspd_pkg::ROW_AW'(tspd_pkg::MAP_ROWS - 1)) begin
            clr_in = 1'b0;
         end
      end else if (set_map) begin
         mem_we = 1'b1;
         row_in = mem_wdata;
      end
      if (load_ff) begin
         row_in = mem_rd_ff;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      data_in      = data_ff;
      opid_in      = opid_ff;
      olast_in     = olast_ff;
      if (emit_data || err) begin
         rsp_valid_in = 1'b1;
         kind_in      = err ? err_kind : tspd_pkg::KIND_DATA;
         data_in      = err ? 8'd0 : b;
         opid_in      = (err_kind == tspd_pkg::KIND_BAD_SYNC) ? 13'd0 : pid_ff;
         olast_in     = last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= map_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         phase_ff     <= tspd_pkg::PH_SYNC;
         pos_ff       <= 8'd0;
         pid_ff       <= 13'd0;
         start_ff     <= 1'b0;
         skip_ff      <= 4'd0;
         begin_ff     <= 8'd0;
         halted_ff    <= 1'b0;
         load_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         pid_ff       <= pid_in;
         start_ff     <= start_in;
         skip_ff      <= skip_in;
         begin_ff     <= begin_in;
         halted_ff    <= halted_in;
         load_ff      <= load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      kind_ff  <= kind_in;
      data_ff  <= data_in;
      opid_ff  <= opid_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = data_ff;
   assign rsp_stream_pid   = opid_ff;
   assign rsp_packet_last  = olast_ff;

   // An error result on the output always comes with a halted parser.
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != tspd_pkg::KIND_DATA) |-> halted_ff)
      else $error("error transfer without halted parser");

   // Once halted, no new result is produced.
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !(emit_data || err))
      else $error("result produced while halted");

   // Outside the clearing pass the map is only written on a completed start code.
   a_map_write: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !clr_ff) |-> (phase_ff == tspd_pkg::PH_CODE && accept))
      else $error("unexpected map write");

   // The map row lands while the control byte is still expected.
   a_row_load: assert property (@(posedge clock) disable iff (reset)
      load_ff |-> phase_ff == tspd_pkg::PH_CTRL)
      else $error("map row loaded out of phase");

   // The byte position stays inside the packet.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= tspd_pkg::LAST_POS)
      else $error("byte position beyond packet end");

endmodule
